### hw/rtl/mwsu_pkg.sv
// ----------------------------------------------------------------------------
// mwsu_pkg
// Shared constants, types and helpers of the maze wall set union block.
// ----------------------------------------------------------------------------
package mwsu_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int MAX_SIDE  = 32;

  localparam int CFG_W    = 6;
  localparam int WALL_W   = 11;
  localparam int COUNT_W  = 10;
  localparam int CELL_AW  = $clog2(MAX_CELLS);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int XW       = (2 * SIDE_W + 1 > WALL_W + 1) ? 2 * SIDE_W + 1 : WALL_W + 1;
  localparam int QW       = $clog2(MAX_SIDE);
  localparam int DIV_SW   = (QW > 1) ? $clog2(QW) : 1;
  localparam int IN_TW    = 16;
  localparam int OUT_TW   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_SIDE = CFG_W'(16);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_CLASS,
    S_DIV,
    S_RD1,
    S_RD2,
    S_CMP,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    int iv;
    iv = int'(v);
    if (iv < 1) iv = 1;
    if (iv > MAX_SIDE) iv = MAX_SIDE;
    return SIDE_W'(iv);
  endfunction

endpackage

### hw/rtl/maze_wall_set_union_top.sv
// ----------------------------------------------------------------------------
// A wall is classified, its two cell labels are read and compared, and on a join
// the relabel pass reads all 1024 label memory entries in turn and rewrites those
// that hold the dropped label. One wall is in work at a time; a new one is taken
// only once the last one's result beat is loaded, which waits on a stalled beat.
// After reset a clear pass loads every label with its own cell index; no wall is
// taken until it ends.
// ----------------------------------------------------------------------------
// maze_wall_set_union_top
// Kruskal maze carving with quick-find disjoint sets held in a label memory.
// ----------------------------------------------------------------------------
module maze_wall_set_union_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mwsu_pkg::IN_TW-1:0]  s_axis_tdata,   // [10:0] wall_index
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [mwsu_pkg::OUT_TW-1:0] m_axis_tdata,   // [0] wall_removed, [1] wall_invalid,
                                                      // [2] maze_complete, [12:3] removed_count
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [mwsu_pkg::CFG_W-1:0]  cfg_data
);

  localparam int XW      = mwsu_pkg::XW;
  localparam int CELL_AW = mwsu_pkg::CELL_AW;
  localparam int COUNT_W = mwsu_pkg::COUNT_W;
  localparam int SIDE_W  = mwsu_pkg::SIDE_W;
  localparam int QW      = mwsu_pkg::QW;
  localparam int DIV_SW  = mwsu_pkg::DIV_SW;

  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(mwsu_pkg::MAX_CELLS - 1);
  localparam logic [XW-1:0]      CELLS_X   = XW'(mwsu_pkg::MAX_CELLS);

  logic [CELL_AW-1:0] mem [mwsu_pkg::MAX_CELLS];
  logic [CELL_AW-1:0] mem_q;
  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [CELL_AW-1:0] mem_wdata;
  logic [CELL_AW-1:0] mem_raddr;

  mwsu_pkg::state_t state, state_next;

  logic [mwsu_pkg::CFG_W-1:0]  grid_width, grid_height;
  logic [CELL_AW-1:0]          clr_cnt, clr_cnt_next;
  logic [CELL_AW-1:0]          scan_cnt, scan_cnt_next;
  logic [XW-1:0]               wall, wall_next;
  logic [2*SIDE_W-1:0]         cells, cells_next;
  logic [XW-1:0]               div_rem, div_rem_next;
  logic [QW-1:0]               div_quo, div_quo_next;
  logic [DIV_SW-1:0]           div_step, div_step_next;
  logic [XW-1:0]               first, first_next;
  logic [XW-1:0]               second, second_next;
  logic [CELL_AW-1:0]          keep, keep_next;
  logic [CELL_AW-1:0]          drop, drop_next;
  logic                        removed, removed_next;
  logic                        invalid, invalid_next;
  logic                        wb_valid, wb_valid_next;
  logic [CELL_AW-1:0]          wb_addr, wb_addr_next;
  logic [COUNT_W-1:0]          count, count_next;
  logic                        out_valid, out_valid_next;
  logic [mwsu_pkg::OUT_TW-1:0] out_data, out_data_next;

  logic [SIDE_W-1:0] w_side, h_side;
  logic [XW-1:0]     cells_x, h_walls, total, shifted;
  logic [QW-1:0]     quo_step;
  logic [XW-1:0]     rem_step;
  logic [XW-1:0]     count_x;
  logic              complete;

  assign w_side = mwsu_pkg::clamp_side(grid_width);
  assign h_side = mwsu_pkg::clamp_side(grid_height);
  assign cells_x = XW'(cells);
  assign h_walls = cells_x - XW'(h_side);
  assign total   = (cells_x << 1) - XW'(w_side) - XW'(h_side);
  assign shifted = XW'(w_side - SIDE_W'(1)) << div_step;

  assign s_axis_tready = (state == mwsu_pkg::S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= mwsu_pkg::RESET_SIDE;
      grid_height <= mwsu_pkg::RESET_SIDE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mwsu_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        mwsu_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mwsu_pkg::S_CLEAR;
      clr_cnt   <= '0;
      wb_valid  <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      wb_valid  <= wb_valid_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt <= scan_cnt_next;
    wall     <= wall_next;
    cells    <= cells_next;
    div_rem  <= div_rem_next;
    div_quo  <= div_quo_next;
    div_step <= div_step_next;
    first    <= first_next;
    second   <= second_next;
    keep     <= keep_next;
    drop     <= drop_next;
    removed  <= removed_next;
    invalid  <= invalid_next;
    wb_addr  <= wb_addr_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    scan_cnt_next  = scan_cnt;
    wall_next      = wall;
    cells_next     = cells;
    div_rem_next   = div_rem;
    div_quo_next   = div_quo;
    div_step_next  = div_step;
    first_next     = first;
    second_next    = second;
    keep_next      = keep;
    drop_next      = drop;
    removed_next   = removed;
    invalid_next   = invalid;
    wb_valid_next  = 1'b0;
    wb_addr_next   = wb_addr;
    count_next     = count;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    mem_raddr      = first[CELL_AW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = wb_addr;
    mem_wdata      = keep;
    rem_step       = div_rem;
    quo_step       = div_quo;
    count_x        = '0;
    complete       = 1'b0;

    // retire a result beat
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    // relabel write-back, in the cycle after the scan read
    if (wb_valid && (mem_q == drop)) begin
      mem_we = 1'b1;
    end

    case (state)
      mwsu_pkg::S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_cnt;
        mem_wdata    = clr_cnt;
        clr_cnt_next = clr_cnt + CELL_AW'(1);
        if (clr_cnt == LAST_CELL) begin
          state_next = mwsu_pkg::S_IDLE;
        end
      end
      mwsu_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          wall_next  = XW'(s_axis_tdata[mwsu_pkg::WALL_W-1:0]);
          state_next = mwsu_pkg::S_PREP;
        end
      end
      mwsu_pkg::S_PREP: begin
        cells_next = w_side * h_side;
        state_next = mwsu_pkg::S_CLASS;
      end
      mwsu_pkg::S_CLASS: begin
        removed_next = 1'b0;
        invalid_next = 1'b0;
        if (wall >= total) begin
          invalid_next = 1'b1;
          state_next   = mwsu_pkg::S_DONE;
        end else if (wall < h_walls) begin
          div_rem_next  = wall;
          div_quo_next  = '0;
          div_step_next = DIV_SW'(QW - 1);
          state_next    = mwsu_pkg::S_DIV;
        end else begin
          first_next  = wall - h_walls;
          second_next = wall - h_walls + XW'(w_side);
          state_next  = mwsu_pkg::S_RD1;
        end
      end
      mwsu_pkg::S_DIV: begin
        if (div_rem >= shifted) begin
          rem_step           = div_rem - shifted;
          quo_step[div_step] = 1'b1;
        end
        div_rem_next  = rem_step;
        div_quo_next  = quo_step;
        div_step_next = div_step - DIV_SW'(1);
        if (div_step == '0) begin
          first_next  = wall + XW'(quo_step);
          second_next = wall + XW'(quo_step) + XW'(1);
          state_next  = mwsu_pkg::S_RD1;
        end
      end
      mwsu_pkg::S_RD1: begin
        mem_raddr = first[CELL_AW-1:0];
        if ((first >= CELLS_X) || (second >= CELLS_X)) begin
          invalid_next = 1'b1;
          state_next   = mwsu_pkg::S_DONE;
        end else begin
          state_next = mwsu_pkg::S_RD2;
        end
      end
      mwsu_pkg::S_RD2: begin
        mem_raddr  = second[CELL_AW-1:0];
        keep_next  = mem_q;
        state_next = mwsu_pkg::S_CMP;
      end
      mwsu_pkg::S_CMP: begin
        drop_next     = mem_q;
        scan_cnt_next = '0;
        if (mem_q != keep) begin
          removed_next = 1'b1;
          state_next   = mwsu_pkg::S_SCAN;
        end else begin
          state_next = mwsu_pkg::S_DONE;
        end
      end
      mwsu_pkg::S_SCAN: begin
        mem_raddr     = scan_cnt;
        wb_valid_next = 1'b1;
        wb_addr_next  = scan_cnt;
        scan_cnt_next = scan_cnt + CELL_AW'(1);
        if (scan_cnt == LAST_CELL) begin
          state_next = mwsu_pkg::S_TAIL;
        end
      end
      mwsu_pkg::S_TAIL: begin
        state_next = mwsu_pkg::S_DONE;
      end
      mwsu_pkg::S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          if (removed && (count != mwsu_pkg::COUNT_MAX)) begin
            count_next = count + COUNT_W'(1);
          end
          count_x  = XW'(count_next) + XW'(1);
          complete = (count_x >= cells_x);
          out_valid_next = 1'b1;
          out_data_next  = mwsu_pkg::OUT_TW'({count_next, complete, invalid, removed});
          state_next     = mwsu_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mwsu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/mwsu_checker.sv
// ----------------------------------------------------------------------------
// mwsu_checker
// Port-level checks of the maze wall set union block, bound to the top level.
// ----------------------------------------------------------------------------
module mwsu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [mwsu_pkg::OUT_TW-1:0] m_axis_tdata
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_removed_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("invalid wall reported as removed");

  a_removed_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[12:3] != '0)
    else $error("removal with zero count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second wall taken while one is in work");

endmodule

bind maze_wall_set_union_top mwsu_checker u_mwsu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
